### hdl/brt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brt_pkg
// Shared types and constants for the block reference count table.
// ----------------------------------------------------------------------------
package brt_pkg;

    localparam int BLK_CNT  = 1024;
    localparam int BLK_AW   = $clog2(BLK_CNT);
    localparam int SNAP_CNT = 64;
    localparam int SNAP_IW  = $clog2(SNAP_CNT);
    localparam int SNAP_W   = 7;
    localparam int CNT_W    = 16;
    localparam int STAT_W   = 2;
    localparam int CMD_W    = 3;
    localparam int BID_W    = 10;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENABLE   = 3'd0,
        CMD_DISABLE  = 3'd1,
        CMD_INC      = 3'd2,
        CMD_DEC      = 3'd3,
        CMD_QUERY    = 3'd4,
        CMD_CREATE   = 3'd5,
        CMD_ROLLBACK = 3'd6,
        CMD_CLEANUP  = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SWEEP,
        OP_INC,
        OP_DEC,
        OP_QUERY,
        OP_CREATE,
        OP_ROLL,
        OP_CLEAN
    } t_op_kind;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BID_W-1:0]  blk_idx;
        logic [SNAP_W-1:0] snap_idx;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  ref_count;
        logic [SNAP_W-1:0] new_snapshot;
    } t_out;

    typedef struct packed {
        t_op_kind           kind;
        logic [BLK_AW-1:0]  addr;
        logic [SNAP_IW-1:0] sidx;
        logic               tied;
        logic [STAT_W-1:0]  status;
        logic [SNAP_W-1:0]  made;
    } t_op;

endpackage
`default_nettype wire

### hdl/block_refcount_snapshot_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_refcount_snapshot_table
// Per-block reference count table with snapshot bookkeeping, split into a
// command front end and a table RAM back end joined by a short queue.
// ----------------------------------------------------------------------------
//   channel | ports                               | payload
//   --------+-------------------------------------+--------------------------
//   in      | i_in_valid  / o_in_ready            | i_in_data  (t_in)
//   out     | o_out_valid / i_out_ready           | o_out_data (t_out)
//   cfg     | i_cfg_valid / o_cfg_ready (always 1) | i_cfg_data (refcount limit)
//
// Increment, decrement, query, rollback and cleanup first read the table RAMs
// in the back end, then update them and load the result.
// Disable, snapshot create and rejected commands need no back-end table read.
// Enable runs a clearing sweep of the count RAM, one entry a cycle, over all
// 1024 entries before its transaction is delivered.
// The front end keeps taking transactions while the two-entry queue has room;
// a stalled output register holds the back end but not the front.
// Reset is synchronous, active low; the count RAM is not cleared by reset,
// since every count is only read after an enable has swept it, and a snapshot
// flag is only read for an id created since the last enable.
// ----------------------------------------------------------------------------
module block_refcount_snapshot_table
    import brt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in              i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CNT_W-1:0] i_cfg_data
);

    logic [CNT_W-1:0] r_refcount_limit;

    logic w_push;
    logic w_pop;
    logic w_q_full;
    logic w_q_empty;
    t_op  w_front_op;
    t_op  w_q_head;

    // Limit register; the user must write it only while the block is idle, the block does not enforce this.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refcount_limit <= {CNT_W{1'b1}};
        end else if (i_cfg_valid) begin
            r_refcount_limit <= i_cfg_data;
        end
    end

    // Accept whenever the queue has a free slot.
    assign o_in_ready = !w_q_full;

    brt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in_data),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_op       (w_front_op)
    );

    brt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_front_op),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    brt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_refcount_limit),
        .i_q_empty   (w_q_empty),
        .i_q_head    (w_q_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule
`default_nettype wire

### hdl/brt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/brt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brt_queue
// Two-entry operation queue between the front and back units.
// ----------------------------------------------------------------------------
module brt_queue
    import brt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_op       o_head
);

    t_op        r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_slot[r_rd_ptr];

endmodule
`default_nettype wire

### hdl/brt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brt_front
// Command front end: owns enable and snapshot numbering, resolves every check
// that needs no table read, and turns each command into a table operation.
// ----------------------------------------------------------------------------
module brt_front
    import brt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_in  i_in,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_op       o_op
);

    logic                r_enabled;
    logic [SNAP_W-1:0]   r_next;
    logic                n_enabled;
    logic [SNAP_W-1:0]   n_next;

    logic                w_accept;
    logic                w_blk_ok;
    logic                w_snap_ok;
    logic [SNAP_IW-1:0]  w_sidx;
    logic [SNAP_IW-1:0]  w_cidx;
    logic [SNAP_W-1:0]   w_snap_m1;
    logic [SNAP_W-1:0]   w_next_m1;

    assign w_accept  = i_in_valid && !i_q_full;
    assign w_snap_m1 = i_in.snap_idx - SNAP_W'(1);
    assign w_next_m1 = r_next - SNAP_W'(1);
    assign w_sidx    = w_snap_m1[SNAP_IW-1:0];
    assign w_cidx    = w_next_m1[SNAP_IW-1:0];

    assign w_blk_ok = r_enabled && (i_in.blk_idx != '0)
                      && (32'(i_in.blk_idx) < 32'(BLK_CNT));

    // Handed out since the last enable; the active flag is checked in the back.
    assign w_snap_ok = r_enabled && (i_in.snap_idx != '0)
                       && (i_in.snap_idx < r_next)
                       && (32'(i_in.snap_idx) <= 32'(SNAP_CNT));

    always_comb begin
        n_enabled   = r_enabled;
        n_next      = r_next;
        o_op.kind   = OP_NONE;
        o_op.addr   = BLK_AW'(i_in.blk_idx);
        o_op.sidx   = w_sidx;
        o_op.tied   = 1'b0;
        o_op.status = ST_OK;
        o_op.made   = '0;
        case (t_cmd'(i_in.command))
            CMD_ENABLE: begin
                o_op.kind = OP_SWEEP;
                n_enabled = 1'b1;
                n_next    = SNAP_W'(1);
            end
            CMD_DISABLE: begin
                n_enabled = 1'b0;
                n_next    = '0;
            end
            CMD_INC, CMD_DEC, CMD_QUERY: begin
                if (!w_blk_ok) begin
                    o_op.status = ST_INVALID;
                end else if (t_cmd'(i_in.command) == CMD_INC) begin
                    o_op.kind = OP_INC;
                end else if (t_cmd'(i_in.command) == CMD_DEC) begin
                    o_op.kind = OP_DEC;
                end else begin
                    o_op.kind = OP_QUERY;
                end
            end
            CMD_CREATE: begin
                if (!r_enabled || r_next == '0) begin
                    o_op.status = ST_INVALID;
                end else if (32'(r_next) > 32'(SNAP_CNT)) begin
                    o_op.status = ST_FULL;
                end else begin
                    n_next    = r_next + SNAP_W'(1);
                    o_op.kind = OP_CREATE;
                    o_op.made = r_next;
                    o_op.addr = BLK_AW'(r_next);
                    o_op.sidx = w_cidx;
                    o_op.tied = (32'(r_next) < 32'(BLK_CNT));
                end
            end
            CMD_ROLLBACK, CMD_CLEANUP: begin
                if (!w_snap_ok) begin
                    o_op.status = ST_INVALID;
                end else begin
                    o_op.addr = BLK_AW'(i_in.snap_idx);
                    o_op.tied = (32'(i_in.snap_idx) < 32'(BLK_CNT));
                    if (t_cmd'(i_in.command) == CMD_CLEANUP) begin
                        o_op.kind = OP_CLEAN;
                    end else begin
                        o_op.kind = OP_ROLL;
                    end
                end
            end
            default: begin
                o_op.status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_next    <= '0;
        end else if (w_accept) begin
            r_enabled <= n_enabled;
            r_next    <= n_next;
        end
    end

    assign o_push = w_accept;

endmodule
`default_nettype wire

### hdl/brt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brt_back
// Table back end: executes queued operations on the count RAM and the
// snapshot flag RAM and drives the registered result.
// ----------------------------------------------------------------------------
module brt_back
    import brt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CNT_W-1:0] i_limit,
    input  wire logic             i_q_empty,
    input  wire t_op              i_q_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } t_state;

    localparam logic [BLK_AW-1:0] LAST_ADDR = BLK_AW'(BLK_CNT - 1);

    t_state             r_state;
    t_state             n_state;
    t_op                r_op;
    t_op                n_op;
    logic [BLK_AW-1:0]  r_sweep;
    logic [BLK_AW-1:0]  n_sweep;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out               r_out;
    t_out               n_out;

    logic               w_out_free;
    logic               w_we;
    logic [BLK_AW-1:0]  w_waddr;
    logic [CNT_W-1:0]   w_wdata;
    logic               w_re;
    logic [CNT_W-1:0]   w_rdata;
    logic               w_act_we;
    logic [SNAP_IW-1:0] w_act_waddr;
    logic               w_act_wdata;
    logic               w_act_rdata;

    brt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BLK_CNT)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (i_q_head.addr),
        .o_rdata (w_rdata)
    );

    // Snapshot active flags; only ids handed out since the last enable are
    // read, and each create writes its flag before any later use.
    brt_ram #(
        .WIDTH (1),
        .DEPTH (SNAP_CNT)
    ) u_active_ram (
        .i_clk   (i_clk),
        .i_we    (w_act_we),
        .i_waddr (w_act_waddr),
        .i_wdata (w_act_wdata),
        .i_re    (w_re),
        .i_raddr (i_q_head.sidx),
        .o_rdata (w_act_rdata)
    );

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_sweep     = r_sweep;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_op.addr;
        w_wdata     = '0;
        w_re        = 1'b0;
        w_act_we    = 1'b0;
        w_act_waddr = r_op.sidx;
        w_act_wdata = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    case (i_q_head.kind)
                        OP_INC, OP_DEC, OP_QUERY, OP_ROLL, OP_CLEAN: begin
                            o_pop   = 1'b1;
                            w_re    = 1'b1;
                            n_op    = i_q_head;
                            n_state = S_EXEC;
                        end
                        OP_SWEEP: begin
                            o_pop   = 1'b1;
                            n_sweep = '0;
                            n_state = S_SWEEP;
                        end
                        default: begin
                            if (w_out_free) begin
                                o_pop              = 1'b1;
                                w_we               = (i_q_head.kind == OP_CREATE)
                                                     && i_q_head.tied;
                                w_waddr            = i_q_head.addr;
                                w_wdata            = CNT_W'(1);
                                w_act_we           = (i_q_head.kind == OP_CREATE);
                                w_act_waddr        = i_q_head.sidx;
                                w_act_wdata        = 1'b1;
                                n_out_valid        = 1'b1;
                                n_out.status       = i_q_head.status;
                                n_out.ref_count    = '0;
                                n_out.new_snapshot = i_q_head.made;
                            end
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = ST_OK;
                    n_out.ref_count    = '0;
                    n_out.new_snapshot = '0;
                    n_state            = S_IDLE;
                    case (r_op.kind)
                        OP_INC: begin
                            if (w_rdata >= i_limit) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_wdata = w_rdata + CNT_W'(1);
                            end
                        end
                        OP_DEC: begin
                            if (w_rdata == '0) begin
                                n_out.status = ST_INVALID;
                            end else begin
                                w_we    = 1'b1;
                                w_wdata = w_rdata - CNT_W'(1);
                            end
                        end
                        OP_ROLL, OP_CLEAN: begin
                            // Drop the tied count; cleanup also retires the id.
                            if (!w_act_rdata) begin
                                n_out.status = ST_INVALID;
                            end else begin
                                w_we     = r_op.tied;
                                w_wdata  = '0;
                                w_act_we = (r_op.kind == OP_CLEAN);
                            end
                        end
                        default: begin
                            n_out.ref_count = w_rdata;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
                if (r_sweep != LAST_ADDR) begin
                    n_sweep = r_sweep + BLK_AW'(1);
                end else if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = ST_OK;
                    n_out.ref_count    = '0;
                    n_out.new_snapshot = '0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_op    <= n_op;
        r_sweep <= n_sweep;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_exec_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (r_op.kind == OP_INC || r_op.kind == OP_DEC
                                 || r_op.kind == OP_QUERY || r_op.kind == OP_ROLL
                                 || r_op.kind == OP_CLEAN))
        else $error("execute state holds an operation without a read");

    a_sweep_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_sweep != LAST_ADDR)
            |=> (r_state == S_SWEEP && r_sweep == $past(r_sweep) + BLK_AW'(1)))
        else $error("clearing sweep skipped or left early");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_pop)
        else $error("queue popped while an operation is in flight");
`endif

endmodule
`default_nettype wire
